// ===== design/c2d_pkg.sv =====
package c2d_pkg;

    // Configuration port
    localparam int CFG_DATA_W   = 24;
    localparam int CFG_IDX_W    = 3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_COEF_TOP   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_MID   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_BOT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_LENGTH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT  = 3'd4;

    // Item kinds carried on tuser
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    // Register widths and reset values
    localparam int COEF_BITS    = 8;
    localparam int ROW_LEN_BITS = 11;
    localparam int ROW_CNT_BITS = 16;
    localparam logic [CFG_DATA_W-1:0]   COEF_TOP_RST   = 24'h00FF00;
    localparam logic [CFG_DATA_W-1:0]   COEF_MID_RST   = 24'hFF04FF;
    localparam logic [CFG_DATA_W-1:0]   COEF_BOT_RST   = 24'h00FF00;
    localparam logic [ROW_LEN_BITS-1:0] ROW_LENGTH_RST = 11'd640;
    localparam logic [ROW_CNT_BITS-1:0] ROW_COUNT_RST  = 16'd480;

    // Input row counter saturates at this width
    localparam int IN_ROW_BITS  = 17;

    // Result
    localparam int OUT_BITS     = 27;
    localparam int OUT_DATA_W   = 32;

    // Queue depths
    localparam int CMD_DEPTH    = 4;
    localparam int OUT_DEPTH    = 8;
    localparam int OUT_CNT_W    = $clog2(OUT_DEPTH + 1);

    // Per-item control from the classifier to the datapath
    typedef struct packed {
        logic emit;
        logic last;
        logic top_zero;
        logic bot_zero;
        logic left_zero;
        logic right_zero;
    } t_ctl;

endpackage

// ===== design/c2d_queue.sv =====
module c2d_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_wr,
    input  logic [WIDTH-1:0]               i_wdata,
    input  logic                           i_rd,
    output logic [WIDTH-1:0]               o_rdata,
    output logic                           o_empty,
    output logic                           o_full,
    output logic [$clog2(DEPTH+1)-1:0]     o_count
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wp, n_wp;
    logic [PTR_W-1:0] r_rp, n_rp;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             w_wr_en;
    logic             w_rd_en;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_count = r_cnt;
    assign o_rdata = r_mem[r_rp];

    assign w_wr_en = i_wr && !o_full;
    assign w_rd_en = i_rd && !o_empty;

    // Pointer and fill count update
    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (w_wr_en) begin
            n_wp = (r_wp == PTR_W'(DEPTH - 1)) ? '0 : r_wp + PTR_W'(1);
        end
        if (w_rd_en) begin
            n_rp = (r_rp == PTR_W'(DEPTH - 1)) ? '0 : r_rp + PTR_W'(1);
        end
        case ({w_wr_en, w_rd_en})
            2'b10:   n_cnt = r_cnt + CNT_W'(1);
            2'b01:   n_cnt = r_cnt - CNT_W'(1);
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

endmodule

// ===== design/c2d_front.sv =====
module c2d_front #(
    parameter int MAX_ROW_LENGTH = 1024,
    parameter int PIXEL_BITS     = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic                                 i_op,
    input  logic signed [PIXEL_BITS-1:0]         i_pixel,
    input  logic [c2d_pkg::ROW_LEN_BITS-1:0]     i_row_length,
    input  logic [c2d_pkg::ROW_CNT_BITS-1:0]     i_row_count,
    input  logic                                 i_q_full,
    input  logic                                 i_clr_busy,
    output logic                                 o_q_wr,
    output logic [$clog2(MAX_ROW_LENGTH)-1:0]    o_q_col,
    output logic signed [PIXEL_BITS-1:0]         o_q_pix,
    output c2d_pkg::t_ctl                        o_q_ctl
);
    import c2d_pkg::*;

    localparam int COL_W = $clog2(MAX_ROW_LENGTH);
    localparam int LEN_W = $clog2(MAX_ROW_LENGTH + 1);
    localparam int CMP_W = (LEN_W > ROW_LEN_BITS) ? LEN_W : ROW_LEN_BITS;

    logic [COL_W-1:0]        r_in_col;
    logic [IN_ROW_BITS-1:0]  r_in_row;
    logic [COL_W-1:0]        r_out_col;
    logic [ROW_CNT_BITS-1:0] r_out_row;

    logic [CMP_W-1:0]        w_len_raw;
    logic [CMP_W-1:0]        w_len;
    logic [IN_ROW_BITS-1:0]  w_cnt;
    logic                    w_accept;
    logic                    w_in_wrap;
    t_ctl                    w_ctl;

    // Effective row length and row count
    assign w_len_raw = CMP_W'(i_row_length);
    assign w_len = (w_len_raw == '0) ? CMP_W'(1) :
                   (w_len_raw > CMP_W'(MAX_ROW_LENGTH)) ? CMP_W'(MAX_ROW_LENGTH) : w_len_raw;
    assign w_cnt = (i_row_count == '0) ? IN_ROW_BITS'(1) : IN_ROW_BITS'(i_row_count);

    assign o_ready  = !i_q_full && !i_clr_busy;
    assign w_accept = i_valid && o_ready;

    // Classify the item by position
    assign w_in_wrap        = (CMP_W'(r_in_col) + CMP_W'(1)) >= w_len;
    assign w_ctl.emit       = (r_in_row >= IN_ROW_BITS'(2)) ||
                              ((r_in_row == IN_ROW_BITS'(1)) && (r_in_col != '0));
    assign w_ctl.top_zero   = (r_out_row == '0);
    assign w_ctl.bot_zero   = (IN_ROW_BITS'(r_out_row) + IN_ROW_BITS'(1)) >= w_cnt;
    assign w_ctl.left_zero  = (r_out_col == '0);
    assign w_ctl.right_zero = (CMP_W'(r_out_col) + CMP_W'(1)) >= w_len;
    assign w_ctl.last       = w_ctl.bot_zero && w_ctl.right_zero;

    assign o_q_wr  = w_accept;
    assign o_q_col = r_in_col;
    assign o_q_pix = (i_op == OP_DRAIN) ? '0 : i_pixel;
    assign o_q_ctl = w_ctl;

    // Position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else if (w_accept) begin
            if (w_in_wrap) begin
                r_in_col <= '0;
                if (r_in_row != '1) begin
                    r_in_row <= r_in_row + IN_ROW_BITS'(1);
                end
            end else begin
                r_in_col <= r_in_col + COL_W'(1);
            end
            if (w_ctl.emit) begin
                if (w_ctl.last) begin
                    r_in_col  <= '0;
                    r_in_row  <= '0;
                    r_out_col <= '0;
                    r_out_row <= '0;
                end else if (w_ctl.right_zero) begin
                    r_out_col <= '0;
                    r_out_row <= r_out_row + ROW_CNT_BITS'(1);
                end else begin
                    r_out_col <= r_out_col + COL_W'(1);
                end
            end
        end
    end

endmodule

// ===== design/c2d_back.sv =====
module c2d_back #(
    parameter int MAX_ROW_LENGTH = 1024,
    parameter int PIXEL_BITS     = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_q_valid,
    input  logic [$clog2(MAX_ROW_LENGTH)-1:0]    i_q_col,
    input  logic signed [PIXEL_BITS-1:0]         i_q_pix,
    input  c2d_pkg::t_ctl                        i_q_ctl,
    output logic                                 o_q_pop,
    output logic                                 o_clr_busy,
    input  logic [c2d_pkg::CFG_DATA_W-1:0]       i_coef_top,
    input  logic [c2d_pkg::CFG_DATA_W-1:0]       i_coef_mid,
    input  logic [c2d_pkg::CFG_DATA_W-1:0]       i_coef_bot,
    input  logic [c2d_pkg::OUT_CNT_W-1:0]        i_out_count,
    output logic                                 o_res_valid,
    output logic signed [c2d_pkg::OUT_BITS-1:0]  o_res_value,
    output logic                                 o_res_last
);
    import c2d_pkg::*;

    localparam int COL_W  = $clog2(MAX_ROW_LENGTH);
    localparam int PROD_W = PIXEL_BITS + COEF_BITS;
    localparam int SUM_W  = PIXEL_BITS + COEF_BITS + 4;
    localparam int CR_W   = OUT_CNT_W + 2;

    // Line memories: lower holds the row above the input, upper the row above that
    logic signed [PIXEL_BITS-1:0] r_mem_lower [MAX_ROW_LENGTH];
    logic signed [PIXEL_BITS-1:0] r_mem_upper [MAX_ROW_LENGTH];

    logic                         r_clr;
    logic [COL_W-1:0]             r_clr_addr;

    logic                         r_p1_valid;
    logic [COL_W-1:0]             r_p1_col;
    logic signed [PIXEL_BITS-1:0] r_p1_pix;
    t_ctl                         r_p1_ctl;
    logic signed [PIXEL_BITS-1:0] r_lower_rd;

    logic                         r_p2_valid;
    logic signed [PIXEL_BITS-1:0] r_p2_pix;
    logic signed [PIXEL_BITS-1:0] r_p2_lower;
    t_ctl                         r_p2_ctl;
    logic signed [PIXEL_BITS-1:0] r_upper_rd;

    logic signed [PIXEL_BITS-1:0] r_win [9];

    logic                         r_p3_valid;
    t_ctl                         r_p3_ctl;

    logic                         r_p4_valid;
    logic                         r_p4_last;
    logic signed [PROD_W-1:0]     r_prod [9];

    logic                         r_p5_valid;
    logic                         r_p5_last;
    logic signed [SUM_W-1:0]      r_row_sum [3];

    logic [CFG_DATA_W-1:0]        w_rows [3];
    logic signed [COEF_BITS-1:0]  w_coef [9];
    logic signed [PROD_W-1:0]     w_prod [9];
    logic [CR_W-1:0]              w_inflight;
    logic signed [SUM_W-1:0]      w_total;
    logic                         w_pop;

    // Output credit: results in flight plus those queued must fit the output queue
    assign w_inflight = CR_W'(r_p1_valid && r_p1_ctl.emit) +
                        CR_W'(r_p2_valid && r_p2_ctl.emit) +
                        CR_W'(r_p3_valid) + CR_W'(r_p4_valid) + CR_W'(r_p5_valid);
    assign w_pop = i_q_valid && !r_clr &&
                   ((CR_W'(i_out_count) + w_inflight) < CR_W'(OUT_DEPTH));

    assign o_q_pop    = w_pop;
    assign o_clr_busy = r_clr;

    // Clearing pass after reset, then the stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr      <= 1'b1;
            r_clr_addr <= '0;
            r_p1_valid <= 1'b0;
            r_p2_valid <= 1'b0;
            r_p3_valid <= 1'b0;
            r_p4_valid <= 1'b0;
            r_p5_valid <= 1'b0;
        end else begin
            if (r_clr) begin
                if (r_clr_addr == COL_W'(MAX_ROW_LENGTH - 1)) begin
                    r_clr <= 1'b0;
                end else begin
                    r_clr_addr <= r_clr_addr + COL_W'(1);
                end
            end
            r_p1_valid <= w_pop;
            r_p2_valid <= r_p1_valid;
            r_p3_valid <= r_p2_valid && r_p2_ctl.emit;
            r_p4_valid <= r_p3_valid;
            r_p5_valid <= r_p4_valid;
        end
    end

    // Line memories: lower is read and written on pop, upper in the cycle after
    always_ff @(posedge i_clk) begin
        if (r_clr) begin
            r_mem_lower[r_clr_addr] <= '0;
            r_mem_upper[r_clr_addr] <= '0;
        end else begin
            if (w_pop) begin
                r_lower_rd         <= r_mem_lower[i_q_col];
                r_mem_lower[i_q_col] <= i_q_pix;
            end
            if (r_p1_valid) begin
                r_upper_rd          <= r_mem_upper[r_p1_col];
                r_mem_upper[r_p1_col] <= r_lower_rd;
            end
        end
    end

    // Stage payloads
    always_ff @(posedge i_clk) begin
        r_p1_col   <= i_q_col;
        r_p1_pix   <= i_q_pix;
        r_p1_ctl   <= i_q_ctl;
        r_p2_pix   <= r_p1_pix;
        r_p2_lower <= r_lower_rd;
        r_p2_ctl   <= r_p1_ctl;
        r_p3_ctl   <= r_p2_ctl;
        r_p4_last  <= r_p3_ctl.last;
        r_p5_last  <= r_p4_last;
    end

    // 3x3 window: shift left, new column enters on the right
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 9; i++) begin
                r_win[i] <= '0;
            end
        end else if (r_p2_valid) begin
            for (int r = 0; r < 3; r++) begin
                r_win[r*3]     <= r_win[r*3 + 1];
                r_win[r*3 + 1] <= r_win[r*3 + 2];
            end
            r_win[2] <= r_upper_rd;
            r_win[5] <= r_p2_lower;
            r_win[8] <= r_p2_pix;
        end
    end

    // Border masking and products
    assign w_rows[0] = i_coef_top;
    assign w_rows[1] = i_coef_mid;
    assign w_rows[2] = i_coef_bot;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                if ((r == 0 && r_p3_ctl.top_zero) || (r == 2 && r_p3_ctl.bot_zero) ||
                    (c == 0 && r_p3_ctl.left_zero) || (c == 2 && r_p3_ctl.right_zero)) begin
                    w_coef[r*3 + c] = '0;
                end else begin
                    w_coef[r*3 + c] = signed'(w_rows[r][c*COEF_BITS +: COEF_BITS]);
                end
                w_prod[r*3 + c] = PROD_W'(w_coef[r*3 + c]) * PROD_W'(r_win[r*3 + c]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 9; i++) begin
            r_prod[i] <= w_prod[i];
        end
    end

    // Row sums, then the total
    always_ff @(posedge i_clk) begin
        for (int r = 0; r < 3; r++) begin
            r_row_sum[r] <= SUM_W'(r_prod[r*3]) + SUM_W'(r_prod[r*3 + 1]) +
                            SUM_W'(r_prod[r*3 + 2]);
        end
    end

    assign w_total     = r_row_sum[0] + r_row_sum[1] + r_row_sum[2];
    assign o_res_valid = r_p5_valid;
    assign o_res_value = OUT_BITS'(w_total);
    assign o_res_last  = r_p5_last;

endmodule

// ===== design/conv2d_3x3_zero_pad_unit.sv =====
// Result path: command queue, stages p1 to p5 and output queue, fed by the transfer of the input
//   item that completes its neighborhood (row_length+1 items after its center pixel).
// Throughput: one item per cycle when the command queue is not full and no clearing pass runs.
// Reset: synchronous, active low; registers return to defaults, then a clearing pass zeroes
//   each of the MAX_ROW_LENGTH entries of the line memories with s_axis_tready low.
module conv2d_3x3_zero_pad_unit #(
    parameter int MAX_ROW_LENGTH = 1024,
    parameter int PIXEL_BITS     = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Input stream
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    input  logic [((PIXEL_BITS+7)/8)*8-1:0]       i_s_axis_tdata,  // [PIXEL_BITS-1:0] pixel_value
    input  logic                                  i_s_axis_tuser,  // [0] op
    // Output stream
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    output logic [c2d_pkg::OUT_DATA_W-1:0]        o_m_axis_tdata,  // [26:0] filtered_value
    output logic                                  o_m_axis_tlast,
    // Register writes
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [c2d_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [c2d_pkg::CFG_DATA_W-1:0]        i_cfg_data
);
    import c2d_pkg::*;

    localparam int COL_W = $clog2(MAX_ROW_LENGTH);
    localparam int CTL_W = $bits(t_ctl);
    localparam int CMD_W = COL_W + PIXEL_BITS + CTL_W;
    localparam int RES_W = OUT_BITS + 1;

    logic [CFG_DATA_W-1:0]   r_coef_top;
    logic [CFG_DATA_W-1:0]   r_coef_mid;
    logic [CFG_DATA_W-1:0]   r_coef_bot;
    logic [ROW_LEN_BITS-1:0] r_row_length;
    logic [ROW_CNT_BITS-1:0] r_row_count;

    logic                         w_fq_wr;
    logic [COL_W-1:0]             w_fq_col;
    logic signed [PIXEL_BITS-1:0] w_fq_pix;
    t_ctl                         w_fq_ctl;
    logic [CMD_W-1:0]             w_cmd_wdata;
    logic [CMD_W-1:0]             w_cmd_rdata;
    logic                         w_cmd_empty;
    logic                         w_cmd_full;
    logic [$clog2(CMD_DEPTH+1)-1:0] w_cmd_count;
    logic                         w_cmd_pop;
    logic                         w_clr_busy;

    logic                         w_res_valid;
    logic signed [OUT_BITS-1:0]   w_res_value;
    logic                         w_res_last;
    logic [RES_W-1:0]             w_res_rdata;
    logic                         w_res_empty;
    logic                         w_res_full;
    logic [OUT_CNT_W-1:0]         w_res_count;

    // Register file, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_top   <= COEF_TOP_RST;
            r_coef_mid   <= COEF_MID_RST;
            r_coef_bot   <= COEF_BOT_RST;
            r_row_length <= ROW_LENGTH_RST;
            r_row_count  <= ROW_COUNT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_COEF_TOP:   r_coef_top   <= i_cfg_data;
                REG_COEF_MID:   r_coef_mid   <= i_cfg_data;
                REG_COEF_BOT:   r_coef_bot   <= i_cfg_data;
                REG_ROW_LENGTH: r_row_length <= i_cfg_data[ROW_LEN_BITS-1:0];
                REG_ROW_COUNT:  r_row_count  <= i_cfg_data[ROW_CNT_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Front: accept and classify
    c2d_front #(
        .MAX_ROW_LENGTH (MAX_ROW_LENGTH),
        .PIXEL_BITS     (PIXEL_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_axis_tvalid),
        .o_ready      (o_s_axis_tready),
        .i_op         (i_s_axis_tuser),
        .i_pixel      (signed'(i_s_axis_tdata[PIXEL_BITS-1:0])),
        .i_row_length (r_row_length),
        .i_row_count  (r_row_count),
        .i_q_full     (w_cmd_full),
        .i_clr_busy   (w_clr_busy),
        .o_q_wr       (w_fq_wr),
        .o_q_col      (w_fq_col),
        .o_q_pix      (w_fq_pix),
        .o_q_ctl      (w_fq_ctl)
    );

    assign w_cmd_wdata = {w_fq_ctl, w_fq_pix, w_fq_col};

    // Command queue between front and datapath
    c2d_queue #(
        .WIDTH (CMD_W),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_fq_wr),
        .i_wdata (w_cmd_wdata),
        .i_rd    (w_cmd_pop),
        .o_rdata (w_cmd_rdata),
        .o_empty (w_cmd_empty),
        .o_full  (w_cmd_full),
        .o_count (w_cmd_count)
    );

    // Datapath: line memories, window, multiply-add
    c2d_back #(
        .MAX_ROW_LENGTH (MAX_ROW_LENGTH),
        .PIXEL_BITS     (PIXEL_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (!w_cmd_empty && (w_cmd_count != '0)),
        .i_q_col     (w_cmd_rdata[COL_W-1:0]),
        .i_q_pix     (signed'(w_cmd_rdata[COL_W +: PIXEL_BITS])),
        .i_q_ctl     (t_ctl'(w_cmd_rdata[CMD_W-1 -: CTL_W])),
        .o_q_pop     (w_cmd_pop),
        .o_clr_busy  (w_clr_busy),
        .i_coef_top  (r_coef_top),
        .i_coef_mid  (r_coef_mid),
        .i_coef_bot  (r_coef_bot),
        .i_out_count (w_res_count),
        .o_res_valid (w_res_valid),
        .o_res_value (w_res_value),
        .o_res_last  (w_res_last)
    );

    // Output queue; credit in the datapath keeps it from overflowing
    c2d_queue #(
        .WIDTH (RES_W),
        .DEPTH (OUT_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_res_valid),
        .i_wdata ({w_res_last, w_res_value}),
        .i_rd    (i_m_axis_tready && !w_res_empty && !w_res_full) ,
        .o_rdata (w_res_rdata),
        .o_empty (w_res_empty),
        .o_full  (),
        .o_count (w_res_count)
    );

    assign w_res_full      = 1'b0;
    assign o_m_axis_tvalid = !w_res_empty;
    assign o_m_axis_tdata  = OUT_DATA_W'(w_res_rdata[OUT_BITS-1:0]);
    assign o_m_axis_tlast  = w_res_rdata[OUT_BITS];

endmodule

// ===== tb/sv/conv2d_3x3_zero_pad_unit_tb.sv =====
module conv2d_3x3_zero_pad_unit_tb;
    import c2d_pkg::*;

    localparam int MAX_LEN    = 1024;
    localparam int PIX_W      = 16;
    localparam int LAT_PAD    = 16;
    localparam int DRAIN_WAIT = 20000;
    localparam int unsigned IN_ROW_MAX = (1 << IN_ROW_BITS) - 1;

    typedef struct packed {
        logic [OUT_BITS-1:0] value;
        logic                last;
    } t_conv_result;

    // Clock, reset and block inputs
    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_op = 1'b0;
    logic [PIX_W-1:0]      s_pix = '0;
    logic                  m_ready = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Block outputs
    logic                  o_s_ready;
    logic                  o_m_valid;
    logic [OUT_DATA_W-1:0] o_m_data;
    logic                  o_m_last;
    logic                  o_cfg_ready;

    // Predicted register contents
    logic [CFG_DATA_W-1:0]   coef_top;
    logic [CFG_DATA_W-1:0]   coef_mid;
    logic [CFG_DATA_W-1:0]   coef_bot;
    logic [ROW_LEN_BITS-1:0] cfg_row_len;
    logic [ROW_CNT_BITS-1:0] cfg_row_cnt;

    // Predicted line stores, window and positions
    logic signed [PIX_W-1:0] row_above2 [MAX_LEN];
    logic signed [PIX_W-1:0] row_above1 [MAX_LEN];
    logic signed [PIX_W-1:0] nbhd [9];
    int unsigned in_row, in_col, out_row, out_col;

    t_conv_result expected_sums [$];

    // Run control and statistics
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    int  stall_len = 0;
    bit  stall_req = 1'b0;
    bit  stall_seen = 1'b0;
    int  stall_left = 0;
    int  items_sent = 0;
    int  results_checked = 0;
    int  reg_writes = 0;
    int  fail_count = 0;

    conv2d_3x3_zero_pad_unit #(
        .MAX_ROW_LENGTH (MAX_LEN),
        .PIXEL_BITS     (PIX_W)
    ) uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_ready),
        .i_s_axis_tdata  (s_pix),
        .i_s_axis_tuser  (s_op),
        .o_m_axis_tvalid (o_m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_data),
        .o_m_axis_tlast  (o_m_last),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    initial begin
        forever #10 clk = ~clk;
    end

    // Row length and count as the block uses them
    function automatic int unsigned eff_len();
        if (cfg_row_len == 0) return 1;
        if (cfg_row_len > MAX_LEN) return MAX_LEN;
        return cfg_row_len;
    endfunction

    function automatic int unsigned eff_cnt();
        return (cfg_row_cnt == 0) ? 1 : cfg_row_cnt;
    endfunction

    function automatic bit at_frame_start();
        return (in_row == 0) && (in_col == 0);
    endfunction

    function automatic longint coef_at(input int r, input int c);
        logic [CFG_DATA_W-1:0] w;
        w = (r == 0) ? coef_top : (r == 1) ? coef_mid : coef_bot;
        return longint'($signed(w[8*c +: 8]));
    endfunction

    function automatic void clear_predictor();
        coef_top    = COEF_TOP_RST;
        coef_mid    = COEF_MID_RST;
        coef_bot    = COEF_BOT_RST;
        cfg_row_len = ROW_LENGTH_RST;
        cfg_row_cnt = ROW_COUNT_RST;
        for (int i = 0; i < MAX_LEN; i++) begin
            row_above2[i] = '0;
            row_above1[i] = '0;
        end
        for (int i = 0; i < 9; i++) nbhd[i] = '0;
        in_row  = 0;
        in_col  = 0;
        out_row = 0;
        out_col = 0;
    endfunction

    // Advance the window by one item and queue the filtered sum it completes
    function automatic void conv_predict(input logic op, input logic [PIX_W-1:0] pix);
        int unsigned len, cnt, col;
        logic signed [PIX_W-1:0] v;
        bit emit, top_z, bot_z, left_z, right_z;
        longint acc;
        t_conv_result res;
        len  = eff_len();
        cnt  = eff_cnt();
        col  = in_col % MAX_LEN;
        v    = (op == OP_DRAIN) ? '0 : pix;
        emit = (in_row >= 2) || (in_row == 1 && in_col >= 1);

        for (int r = 0; r < 3; r++) begin
            nbhd[r*3]   = nbhd[r*3+1];
            nbhd[r*3+1] = nbhd[r*3+2];
        end
        nbhd[2] = row_above2[col];
        nbhd[5] = row_above1[col];
        nbhd[8] = v;
        row_above2[col] = row_above1[col];
        row_above1[col] = v;

        if (in_col + 1 >= len) begin
            in_col = 0;
            if (in_row < IN_ROW_MAX) in_row++;
        end else begin
            in_col++;
        end
        if (!emit) return;

        // border taps count as zero
        top_z   = (out_row == 0);
        bot_z   = (out_row + 1 >= cnt);
        left_z  = (out_col == 0);
        right_z = (out_col + 1 >= len);
        acc = 0;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                if ((r == 0 && top_z) || (r == 2 && bot_z)) continue;
                if ((c == 0 && left_z) || (c == 2 && right_z)) continue;
                acc += coef_at(r, c) * longint'(nbhd[r*3+c]);
            end
        end
        res.value = acc[OUT_BITS-1:0];
        res.last  = bot_z && right_z;
        expected_sums.push_back(res);

        if (res.last) begin
            in_row  = 0;
            in_col  = 0;
            out_row = 0;
            out_col = 0;
        end else if (right_z) begin
            out_col = 0;
            out_row = (out_row + 1) & 16'hFFFF;
        end else begin
            out_col++;
        end
    endfunction

    function automatic logic [PIX_W-1:0] rand_pixel();
        case ($urandom_range(19))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'hFFFF;
            3:       return 16'h0000;
            default: return PIX_W'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_coefs();
        case ($urandom_range(9))
            0:       return 24'h808080;
            1:       return 24'h7F7F7F;
            2:       return 24'h000000;
            default: return CFG_DATA_W'($urandom);
        endcase
    endfunction

    // Compare one output transfer against the oldest expected sum
    task automatic check_result(input logic [OUT_BITS-1:0] got_val, input logic got_last);
        t_conv_result exp_r;
        if (expected_sums.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
                $display("unexpected result: value %0d last %0b",
                         $signed(got_val), got_last);
            return;
        end
        exp_r = expected_sums.pop_front();
        results_checked++;
        if (got_val !== exp_r.value || got_last !== exp_r.last) begin
            fail_count++;
            if (fail_count <= 10)
                $display("mismatch on result %0d: expected value %0d last %0b, got %0d last %0b",
                         results_checked, $signed(exp_r.value), exp_r.last,
                         $signed(got_val), got_last);
        end
    endtask

    // Output side: check transfers, then pick tready for the next cycle
    always @(posedge clk) begin
        if (rst_n && o_m_valid && m_ready)
            check_result(o_m_data[OUT_BITS-1:0], o_m_last);
        if (stall_req != stall_seen) begin
            stall_seen = stall_req;
            stall_left = stall_len;
        end
        if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // One input transfer; each cycle ahead of it idles with the sender's odds
    task automatic send_item(input logic op, input logic [PIX_W-1:0] pix);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge clk);
        end
        s_valid <= 1'b1;
        s_op    <= op;
        s_pix   <= pix;
        @(posedge clk);
        while (!o_s_ready) @(posedge clk);
        conv_predict(op, pix);
        items_sent++;
    endtask

    // Stop sending and let every pending result come out
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (expected_sums.size() != 0) @(posedge clk);
        repeat (LAT_PAD) @(posedge clk);
    endtask

    // Register write; tvalid stays up for back-to-back writes
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
        while (!o_cfg_ready) @(posedge clk);
        case (idx)
            REG_COEF_TOP:   coef_top    = d;
            REG_COEF_MID:   coef_mid    = d;
            REG_COEF_BOT:   coef_bot    = d;
            REG_ROW_LENGTH: cfg_row_len = d[ROW_LEN_BITS-1:0];
            REG_ROW_COUNT:  cfg_row_cnt = d[ROW_CNT_BITS-1:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic apply_config(input logic [CFG_DATA_W-1:0] top, input logic [CFG_DATA_W-1:0] mid,
                                input logic [CFG_DATA_W-1:0] bot, input int len, input int cnt);
        wait_idle();
        write_reg(REG_COEF_TOP, top);
        write_reg(REG_COEF_MID, mid);
        write_reg(REG_COEF_BOT, bot);
        write_reg(REG_ROW_LENGTH, CFG_DATA_W'(len));
        write_reg(REG_ROW_COUNT, CFG_DATA_W'(cnt));
        cfg_valid <= 1'b0;
    endtask

    // One image plus its drain; a broken frame gets a random drain count
    task automatic send_frame(input bit broken);
        int unsigned len, cnt, drains;
        len = eff_len();
        cnt = eff_cnt();
        for (int unsigned i = 0; i < len * cnt; i++) begin
            if ($urandom_range(99) < 5) send_item(OP_DRAIN, rand_pixel());
            else                        send_item(OP_PIXEL, rand_pixel());
        end
        drains = broken ? $urandom_range(0, len + 4) : len + 1;
        for (int unsigned i = 0; i < drains; i++) begin
            if ($urandom_range(99) < 20) send_item(OP_PIXEL, rand_pixel());
            else                         send_item(OP_DRAIN, rand_pixel());
        end
    endtask

    // Drain until the counters are back at the start of an image
    task automatic flush_frame();
        while (!at_frame_start()) send_item(OP_DRAIN, rand_pixel());
    endtask

    // Extremes of pixel values, both kinds of items in both places, tiny and degenerate sizes
    task automatic test_directed_borders();
        apply_config(COEF_TOP_RST, COEF_MID_RST, COEF_BOT_RST, 3, 3);
        send_item(OP_PIXEL, 16'h8000);
        send_item(OP_PIXEL, 16'h7FFF);
        send_item(OP_PIXEL, 16'h8000);
        send_item(OP_PIXEL, 16'h7FFF);
        send_item(OP_DRAIN, 16'h1234);   // drain in the middle of the image
        send_item(OP_PIXEL, 16'hFFFF);
        send_item(OP_PIXEL, 16'h0001);
        send_item(OP_PIXEL, 16'h7FFF);
        send_item(OP_PIXEL, 16'h8000);
        send_item(OP_DRAIN, 16'h0000);
        send_item(OP_PIXEL, 16'h7FFF);   // pixel in a drain slot
        send_item(OP_DRAIN, 16'hFFFF);
        send_item(OP_DRAIN, 16'h0000);

        // largest positive sum: all taps -128, all pixels -32768
        apply_config(24'h808080, 24'h808080, 24'h808080, 2, 2);
        repeat (4) send_item(OP_PIXEL, 16'h8000);
        repeat (3) send_item(OP_DRAIN, 16'h0000);

        // single pixel image, then zero length and count taken as one
        apply_config(24'h7F807F, 24'h807F80, 24'h7F807F, 1, 1);
        send_item(OP_PIXEL, 16'h8000);
        send_item(OP_DRAIN, 16'h5555);
        send_item(OP_DRAIN, 16'hAAAA);
        apply_config(24'h7F807F, 24'h7F807F, 24'h7F807F, 0, 0);
        send_item(OP_PIXEL, 16'h7FFF);
        send_item(OP_DRAIN, 16'h0000);
        send_item(OP_DRAIN, 16'h0000);
    endtask

    // Row length beyond the line store depth walks every column; a shorter
    // row length written part way through the drain ends the image early
    task automatic test_row_length_limits();
        send_idle_pct = 0;
        recv_idle_pct <= 0;
        apply_config(rand_coefs(), rand_coefs(), rand_coefs(), 2047, 1);
        repeat (MAX_LEN) send_item(OP_PIXEL, rand_pixel());
        repeat (40) send_item(OP_DRAIN, rand_pixel());
        wait_idle();
        write_reg(REG_ROW_LENGTH, 24'd8);
        cfg_valid <= 1'b0;
        flush_frame();
    endtask

    // Row count and taps changed part way through an image
    task automatic test_live_update();
        apply_config(rand_coefs(), rand_coefs(), rand_coefs(), 4, 65535);
        repeat (12) send_item(OP_PIXEL, rand_pixel());
        wait_idle();
        write_reg(REG_ROW_COUNT, 24'd2);
        write_reg(REG_COEF_MID, rand_coefs());
        cfg_valid <= 1'b0;
        repeat (5) send_item(OP_DRAIN, rand_pixel());
        flush_frame();
    endtask

    // Mostly well-formed frames of random size and content, some with a broken drain
    task automatic test_random_frames(input int n, input int s_pct, input int r_pct);
        int start;
        bit first;
        int len;
        int cnt;
        send_idle_pct = s_pct;
        recv_idle_pct <= r_pct;
        start = items_sent;
        first = 1'b1;
        while (items_sent - start < n) begin
            if (at_frame_start() && (first || $urandom_range(99) < 60)) begin
                case ($urandom_range(19))
                    0:       len = $urandom_range(41, 100);
                    1, 2, 3: len = $urandom_range(9, 40);
                    default: len = $urandom_range(1, 8);
                endcase
                cnt = (len > 40) ? $urandom_range(1, 3) : $urandom_range(1, 10);
                apply_config(rand_coefs(), rand_coefs(), rand_coefs(), len, cnt);
                first = 1'b0;
            end
            send_frame($urandom_range(99) < 10);
        end
        flush_frame();
    endtask

    // Output held off long enough to fill the block while input keeps coming
    task automatic test_backpressure();
        apply_config(rand_coefs(), rand_coefs(), rand_coefs(), 8, 12);
        send_idle_pct = 0;
        recv_idle_pct <= 0;
        stall_len <= 300;
        stall_req <= ~stall_req;
        send_frame(1'b0);
        wait_idle();
    endtask

    initial begin
        int guard;
        clear_predictor();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_borders();
        test_row_length_limits();
        test_live_update();
        test_backpressure();
        test_random_frames(100, 17, 55);
        test_random_frames(100, 55, 17);
        test_random_frames(100, 0, 0);

        // let the tail of the run come out
        s_valid <= 1'b0;
        guard = 0;
        while (expected_sums.size() != 0 && guard < DRAIN_WAIT) begin
            @(posedge clk);
            guard++;
        end
        if (expected_sums.size() != 0) begin
            fail_count++;
            $display("%0d expected results never arrived", expected_sums.size());
        end
        repeat (LAT_PAD) @(posedge clk);

        $display("Sent %0d pixel/drain transfers over %0d register writes,", items_sent,
                 reg_writes);
        $display("checked %0d filtered results; %0d failures", results_checked, fail_count);
        if (fail_count == 0)
            $display("PASS conv2d_3x3_zero_pad_unit");
        else
            $display("FAIL conv2d_3x3_zero_pad_unit");
        $finish;
    end

    // Watchdog
    initial begin
        #10000000;
        $display("run timed out");
        $display("FAIL conv2d_3x3_zero_pad_unit");
        $finish;
    end

endmodule
